>>> src/ptx_pkg.sv
// Shared action codes and word sizes for the 4x4 point transform.
`default_nettype none
package ptx_pkg;
  localparam int WORD_W = 32;

  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_AFFINE = 3'd1;
  localparam logic [2:0] ACT_ROT    = 3'd2;
  localparam logic [2:0] ACT_INVRIG = 3'd3;
  localparam logic [2:0] ACT_TROT   = 3'd4;
  localparam logic [2:0] ACT_PROJ   = 3'd5;
  localparam logic [2:0] ACT_POSTT  = 3'd6;
  localparam logic [2:0] ACT_PRET   = 3'd7;

  typedef logic signed [WORD_W-1:0] word_t;
endpackage
`default_nettype wire

>>> src/point_transform_4x4.sv
// Top level: 4x4 fixed-point matrix store with a shared multiply-accumulate and divider.
//
//  channel | direction | fields
//  pt      | in        | action, entry_row, entry_col, entry_value, point_x/y/z
//  res     | out       | out_x, out_y, out_z, overflow_flag, zero_w_flag
//
// One item at a time; pt_ready is high only while idle. A load leaves the sequencer idle.
// From the accepting edge to res_valid, each output row runs 3 multiply/accumulate
// pairs plus add and saturate steps for affine and pre-translate; inverse rigid
// first subtracts the translation from each of the 3 coordinates, and it and the two
// rotations skip the add step; post-translate runs only the add and saturate steps.
// Projective first computes w the same way, then per row does the same steps plus a
// restoring division of 33+FRAC_BITS quotient bits (49 at Q16.16); a zero w ends after w.
// Reset (rst, synchronous) loads identity into the matrix and idles the sequencer.
// A result waits in its output registers until res_ready takes it, and the
// sequencer then returns to idle, where it can accept the next item.
`default_nettype none
module point_transform_4x4
  import ptx_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pt_valid,
  output logic                   pt_ready,
  input  wire logic [2:0]        action,
  input  wire logic [1:0]        entry_row,
  input  wire logic [1:0]        entry_col,
  input  wire logic signed [31:0] entry_value,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic signed [31:0]     out_x,
  output logic signed [31:0]     out_y,
  output logic signed [31:0]     out_z,
  output logic                   overflow_flag,
  output logic                   zero_w_flag
);
  localparam int PW = 2*WORD_W + 1;      // product width
  localparam int AW = PW + 2;            // accumulator width
  localparam int DW = WORD_W + 1 + FRAC_BITS; // dividend width
  localparam int CW = $clog2(DW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUB  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_ADDT = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_QFIN = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic signed [AW-1:0] ACC_MAX = $signed({{(AW-WORD_W){1'b0}}, {1'b0, {(WORD_W-1){1'b1}}}});
  localparam logic signed [AW-1:0] ACC_MIN = $signed({{(AW-WORD_W){1'b1}}, {1'b1, {(WORD_W-1){1'b0}}}});
  localparam logic [DW-1:0] QPOS_MAX = {{(DW-WORD_W){1'b0}}, 1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [DW-1:0] QNEG_MAX = {{(DW-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}};

  logic [3:0]              state;
  logic [2:0]              act;
  logic [1:0]              row;
  logic [1:0]              k;
  logic signed [WORD_W:0]  pr [3];
  logic signed [WORD_W-1:0] mat [16];
  logic signed [PW-1:0]    prod;
  logic signed [AW-1:0]    acc;
  logic signed [WORD_W-1:0] res [3];
  logic signed [WORD_W-1:0] wv;
  logic                    ov;
  logic                    zw;
  logic                    qneg;
  logic [DW-1:0]           dv;
  logic [DW-1:0]           qm;
  logic [WORD_W+1:0]       rem;
  logic [WORD_W:0]         absw;
  logic [CW-1:0]           dcnt;

  logic [3:0]              raddr;
  logic signed [WORD_W-1:0] mrd;
  logic signed [WORD_W:0]  bop;
  logic signed [WORD_W:0]  prow;
  logic signed [WORD_W-1:0] sat;
  logic                    sat_ov;
  logic [WORD_W+1:0]       trial;
  logic [WORD_W:0]         absn;
  logic signed [WORD_W-1:0] qres;
  logic                    q_ov;
  logic                    transp;

  assign pt_ready  = (state == S_IDLE);
  assign res_valid = (state == S_OUT);
  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign overflow_flag = ov;
  assign zero_w_flag   = zw;

  // Select the matrix word for the current step
  assign transp = (act == ACT_INVRIG) || (act == ACT_TROT);
  always_comb begin
    case (state)
      S_SUB, S_ADDT: raddr = {row, 2'd3};
      S_MUL:         raddr = transp ? {k, row} : {row, k};
      default:       raddr = {row, k};
    endcase
  end
  assign mrd = mat[raddr];

  // Point operands by position
  always_comb begin
    case (k)
      2'd0:    bop = pr[0];
      2'd1:    bop = pr[1];
      default: bop = pr[2];
    endcase
    case (row)
      2'd0:    prow = pr[0];
      2'd1:    prow = pr[1];
      default: prow = pr[2];
    endcase
  end

  // Saturate the accumulator to one word
  always_comb begin
    sat_ov = 1'b0;
    sat    = acc[WORD_W-1:0];
    if (acc > ACC_MAX) begin
      sat_ov = 1'b1;
      sat    = ACC_MAX[WORD_W-1:0];
    end else if (acc < ACC_MIN) begin
      sat_ov = 1'b1;
      sat    = ACC_MIN[WORD_W-1:0];
    end
  end

  // Divider step and quotient sign/saturation
  assign trial = {rem[WORD_W:0], dv[DW-1]};
  assign absn  = sat[WORD_W-1] ? (WORD_W+1)'(-$signed({sat[WORD_W-1], sat}))
                               : {1'b0, sat};
  always_comb begin
    q_ov = 1'b0;
    qres = '0;
    if (qneg) begin
      if (qm > QNEG_MAX) begin
        q_ov = 1'b1;
        qres = QNEG_MAX[WORD_W-1:0];
      end else begin
        qres = WORD_W'(-qm);
      end
    end else begin
      if (qm > QPOS_MAX) begin
        q_ov = 1'b1;
        qres = QPOS_MAX[WORD_W-1:0];
      end else begin
        qres = qm[WORD_W-1:0];
      end
    end
  end

  // Sequencer, datapath and matrix store
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 16; i++) begin
        mat[i] <= ((i % 5) == 0) ? (WORD_W)'(64'd1 << FRAC_BITS) : '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (pt_valid) begin
            if (action == ACT_LOAD) begin
              mat[{entry_row, entry_col}] <= entry_value;
            end else begin
              act   <= action;
              pr[0] <= {point_x[31], point_x};
              pr[1] <= {point_y[31], point_y};
              pr[2] <= {point_z[31], point_z};
              row   <= (action == ACT_PROJ) ? 2'd3 : 2'd0;
              k     <= 2'd0;
              acc   <= '0;
              ov    <= 1'b0;
              zw    <= 1'b0;
              if (action == ACT_INVRIG) state <= S_SUB;
              else if (action == ACT_POSTT) state <= S_ADDT;
              else state <= S_MUL;
            end
          end
        end
        S_SUB: begin
          // Remove translation from the point, one coordinate a cycle
          pr[row] <= prow - {mrd[WORD_W-1], mrd};
          if (row == 2'd2) begin
            row   <= 2'd0;
            state <= S_MUL;
          end else begin
            row <= row + 2'd1;
          end
        end
        S_MUL: begin
          prod  <= mrd * bop;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + AW'(prod >>> FRAC_BITS);
          if (k == 2'd2) begin
            k <= 2'd0;
            if (act == ACT_AFFINE || act == ACT_PRET || act == ACT_PROJ) state <= S_ADDT;
            else state <= S_FIN;
          end else begin
            k     <= k + 2'd1;
            state <= S_MUL;
          end
        end
        S_ADDT: begin
          // Add the translation column, and the point for post-translate
          acc <= acc + AW'(mrd) + ((act == ACT_POSTT) ? AW'(prow) : '0);
          state <= S_FIN;
        end
        S_FIN: begin
          if (act == ACT_PROJ && row == 2'd3) begin
            wv  <= sat;
            acc <= '0;
            if (sat == '0) begin
              ov     <= 1'b0;
              zw     <= 1'b1;
              res[0] <= '0;
              res[1] <= '0;
              res[2] <= '0;
              state  <= S_OUT;
            end else begin
              ov    <= ov | sat_ov;
              row   <= 2'd0;
              state <= S_MUL;
            end
          end else if (act == ACT_PROJ) begin
            ov    <= ov | sat_ov;
            acc   <= '0;
            qneg  <= sat[WORD_W-1] ^ wv[WORD_W-1];
            dv    <= DW'(absn) << FRAC_BITS;
            absw  <= wv[WORD_W-1] ? (WORD_W+1)'(-$signed({wv[WORD_W-1], wv}))
                                  : {1'b0, wv};
            rem   <= '0;
            qm    <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end else begin
            ov       <= ov | sat_ov;
            res[row] <= sat;
            if (act == ACT_POSTT || act == ACT_PRET) mat[{row, 2'd3}] <= sat;
            acc <= '0;
            if (row == 2'd2) begin
              state <= S_OUT;
            end else begin
              row   <= row + 2'd1;
              state <= (act == ACT_POSTT) ? S_ADDT : S_MUL;
            end
          end
        end
        S_DIV: begin
          // One quotient bit a cycle, restoring
          if (trial >= {1'b0, absw}) begin
            rem <= trial - {1'b0, absw};
            qm  <= {qm[DW-2:0], 1'b1};
          end else begin
            rem <= trial;
            qm  <= {qm[DW-2:0], 1'b0};
          end
          dv   <= dv << 1;
          dcnt <= dcnt + CW'(1);
          if (dcnt == CW'(DW - 1)) state <= S_QFIN;
        end
        S_QFIN: begin
          ov       <= ov | q_ov;
          res[row] <= qres;
          if (row == 2'd2) begin
            state <= S_OUT;
          end else begin
            row   <= row + 2'd1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/ptx_checker.sv
// Port-level checks for the point transform, bound to the top level.
`default_nettype none
module ptx_assert
  import ptx_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pt_valid,
  input wire logic        pt_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] out_x,
  input wire logic [31:0] out_y,
  input wire logic [31:0] out_z,
  input wire logic        overflow_flag,
  input wire logic        zero_w_flag
);
  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("result changed while stalled");

  // One item at a time
  a_one: assert property (@(posedge clk) disable iff (rst) res_valid |-> !pt_ready)
    else $error("input ready while result pending");

  // An accepted item never yields a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst) pt_valid && pt_ready |=> !res_valid)
    else $error("result too early");

  // Zero w gives zero coordinates and no overflow
  a_zw: assert property (@(posedge clk) disable iff (rst)
    res_valid && zero_w_flag |-> out_x == 0 && out_y == 0 && out_z == 0 && !overflow_flag)
    else $error("zero w result malformed");

  // Return to ready once the result is taken
  a_back: assert property (@(posedge clk) disable iff (rst) res_valid && res_ready |=> pt_ready)
    else $error("not ready after result");
endmodule

bind point_transform_4x4 ptx_assert u_ptx_assert (
  .clk(clk), .rst(rst), .pt_valid(pt_valid), .pt_ready(pt_ready),
  .res_valid(res_valid), .res_ready(res_ready), .out_x(out_x), .out_y(out_y),
  .out_z(out_z), .overflow_flag(overflow_flag), .zero_w_flag(zero_w_flag)
);
`default_nettype wire
